/* rtl/sttok_pkg.sv */
// Shared types, character codes, token kinds and lookup functions of the tokenizer.
package sttok_pkg;

  localparam int MAX_RES = 8;
  localparam int KW_BUF  = 6;
  localparam int NUM_KW  = 16;
  localparam int POS_W   = 16;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  localparam logic [5:0] K_STRING = 6'd0;
  localparam logic [5:0] K_DEC    = 6'd1;
  localparam logic [5:0] K_FLOAT  = 6'd2;
  localparam logic [5:0] K_IDENT  = 6'd3;
  localparam logic [5:0] K_KW0    = 6'd4;
  localparam logic [5:0] K_OP2    = 6'd20;
  localparam logic [5:0] K_OP1    = 6'd24;

  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_SQ  = 8'h27;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_EQ  = 8'h3D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_N   = 8'h6E;
  localparam logic [7:0] CH_T   = 8'h74;
  localparam logic [7:0] CH_R   = 8'h72;

  localparam logic [47:0] KW_STR [NUM_KW] = '{
    "and   ", "class ", "else  ", "if    ", "false ", "true  ", "fun   ", "for   ",
    "void  ", "or    ", "return", "this  ", "int   ", "float ", "cint  ", "cfloat"
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd3, 3'd5, 3'd4, 3'd2, 3'd5, 3'd4, 3'd3, 3'd3,
    3'd4, 3'd2, 3'd6, 3'd4, 3'd3, 3'd5, 3'd4, 3'd6
  };

  typedef struct packed {
    logic       rend;
    logic [5:0] kind;
    logic [7:0] lbyte;
    logic       newst;
    logic       endpos;
    logic       unterm;
  } rec_t;

  typedef struct packed {
    rec_t [MAX_RES-1:0] recs;
    logic [3:0]         nrec;
    logic [POS_W-1:0]   sline0;
    logic [POS_W-1:0]   scol0;
    logic [POS_W-1:0]   sline1;
    logic [POS_W-1:0]   scol1;
    logic [POS_W-1:0]   pline;
    logic [POS_W-1:0]   pcol;
  } burst_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_word_start(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F};
  endfunction

  // {found, index} in the one-byte operator list
  function automatic logic [5:0] single_lookup(input logic [7:0] c);
    logic [5:0] r;
    case (c)
      8'h2B:   r = {1'b1, 5'd0};
      8'h2D:   r = {1'b1, 5'd1};
      8'h2A:   r = {1'b1, 5'd2};
      8'h2F:   r = {1'b1, 5'd3};
      8'h25:   r = {1'b1, 5'd4};
      8'h26:   r = {1'b1, 5'd5};
      8'h7C:   r = {1'b1, 5'd6};
      8'h7E:   r = {1'b1, 5'd7};
      8'h5E:   r = {1'b1, 5'd8};
      8'h28:   r = {1'b1, 5'd9};
      8'h29:   r = {1'b1, 5'd10};
      8'h2C:   r = {1'b1, 5'd11};
      8'h3B:   r = {1'b1, 5'd12};
      8'h3A:   r = {1'b1, 5'd13};
      8'h7B:   r = {1'b1, 5'd14};
      8'h7D:   r = {1'b1, 5'd15};
      8'h5B:   r = {1'b1, 5'd16};
      8'h5D:   r = {1'b1, 5'd17};
      8'h21:   r = {1'b1, 5'd18};
      8'h3D:   r = {1'b1, 5'd19};
      8'h3E:   r = {1'b1, 5'd20};
      8'h3C:   r = {1'b1, 5'd21};
      default: r = '0;
    endcase
    return r;
  endfunction

  // {found, index} among the first bytes of two-byte operators
  function automatic logic [2:0] double_lookup(input logic [7:0] c);
    logic [2:0] r;
    case (c)
      8'h3C:   r = {1'b1, 2'd0};
      8'h3E:   r = {1'b1, 2'd1};
      8'h3D:   r = {1'b1, 2'd2};
      8'h21:   r = {1'b1, 2'd3};
      default: r = '0;
    endcase
    return r;
  endfunction

  // {unknown, value} of an escaped byte
  function automatic logic [8:0] esc_decode(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      CH_BSL:  r = {1'b0, CH_BSL};
      CH_N:    r = {1'b0, CH_LF};
      CH_T:    r = {1'b0, CH_TAB};
      CH_R:    r = {1'b0, CH_CR};
      CH_DQ:   r = {1'b0, CH_DQ};
      CH_SQ:   r = {1'b0, CH_SQ};
      default: r = {1'b1, c};
    endcase
    return r;
  endfunction

  // {hit, keyword index}
  function automatic logic [4:0] kw_lookup(input logic [KW_BUF-1:0][7:0] w,
                                           input logic [2:0] len);
    logic [4:0] r;
    logic       eq;
    r = '0;
    for (int k = 0; k < NUM_KW; k++) begin
      eq = (len == KW_LEN[k]);
      for (int i = 0; i < KW_BUF; i++) begin
        if (i < int'(KW_LEN[k]) && w[i] != KW_STR[k][47-8*i -: 8]) eq = 1'b0;
      end
      if (eq && !r[4]) r = {1'b1, 4'(k)};
    end
    return r;
  endfunction

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

endpackage

/* rtl/sttok_scan.sv */
// Scanner state and the per-byte record list of the tokenizer.
module sttok_scan
  import sttok_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] text_byte_in,
  input  logic       end_of_text,
  output burst_t     burst
);

  typedef enum logic [2:0] {M_IDLE, M_STRING, M_ESC, M_NUMBER, M_WORD, M_OPER} mode_t;

  mode_t                  mode, mode_next;
  logic [7:0]             pend, pend_next;
  logic [KW_BUF-1:0][7:0] wbuf, wbuf_next;
  logic [2:0]             wlen, wlen_next;
  logic                   dseen, dseen_next;
  logic [7:0]             oq, oq_next;
  logic [POS_W-1:0]       line, line_next, col, col_next;
  logic [POS_W-1:0]       sline, sline_next, scol, scol_next;

  rec_t [MAX_RES-1:0] recs;
  logic [3:0]         n;
  logic               mk, do_idle;
  logic [5:0]         op, pop;
  logic [2:0]         dl, pdl;
  logic [8:0]         esc;
  logic [4:0]         kw;
  logic [7:0]         c;

  function automatic rec_t mkrec(input logic rend, input logic [5:0] kind,
                                 input logic [7:0] b, input logic newst,
                                 input logic endpos, input logic unterm);
    rec_t r;
    r.rend   = rend;
    r.kind   = kind;
    r.lbyte  = b;
    r.newst  = newst;
    r.endpos = endpos;
    r.unterm = unterm;
    return r;
  endfunction

  always_comb begin
    c          = text_byte_in;
    mode_next  = mode;
    pend_next  = pend;
    wbuf_next  = wbuf;
    wlen_next  = wlen;
    dseen_next = dseen;
    oq_next    = oq;
    sline_next = sline;
    scol_next  = scol;
    line_next  = line;
    col_next   = col;
    recs       = '0;
    n          = '0;
    mk         = 1'b0;
    do_idle    = 1'b0;
    op         = single_lookup(c);
    dl         = double_lookup(c);
    pdl        = double_lookup(pend);
    esc        = esc_decode(c);
    kw         = '0;
    pop        = '0;

    case (mode)
      M_STRING: begin
        if (c == CH_BSL) begin
          mode_next = M_ESC;
        end else if (c == oq) begin
          recs[n[2:0]] = mkrec(1'b1, K_STRING, 8'd0, mk, 1'b1, 1'b0); n = n + 4'd1;
          mode_next = M_IDLE;
        end else begin
          recs[n[2:0]] = mkrec(1'b0, K_STRING, c, mk, 1'b0, 1'b0); n = n + 4'd1;
        end
      end
      M_ESC: begin
        if (esc[8]) begin
          recs[n[2:0]] = mkrec(1'b0, K_STRING, CH_BSL, mk, 1'b0, 1'b0); n = n + 4'd1;
        end
        recs[n[2:0]] = mkrec(1'b0, K_STRING, esc[7:0], mk, 1'b0, 1'b0); n = n + 4'd1;
        mode_next = M_STRING;
      end
      M_NUMBER: begin
        if (is_digit(c) || c == CH_DOT) begin
          if (c == CH_DOT) dseen_next = 1'b1;
          recs[n[2:0]] = mkrec(1'b0, dseen_next ? K_FLOAT : K_DEC, c, mk, 1'b0, 1'b0);
          n = n + 4'd1;
        end else begin
          recs[n[2:0]] = mkrec(1'b1, dseen ? K_FLOAT : K_DEC, 8'd0, mk, 1'b0, 1'b0);
          n = n + 4'd1;
          do_idle = 1'b1;
        end
      end
      M_WORD: begin
        if (is_word_start(c) || is_digit(c)) begin
          if (wlen >= 3'd7) begin
            recs[n[2:0]] = mkrec(1'b0, K_IDENT, c, mk, 1'b0, 1'b0); n = n + 4'd1;
          end else if (wlen < 3'(KW_BUF)) begin
            wbuf_next[wlen] = c;
            wlen_next       = wlen + 3'd1;
          end else begin
            for (int i = 0; i < KW_BUF; i++) begin
              recs[n[2:0]] = mkrec(1'b0, K_IDENT, wbuf[i], mk, 1'b0, 1'b0); n = n + 4'd1;
            end
            recs[n[2:0]] = mkrec(1'b0, K_IDENT, c, mk, 1'b0, 1'b0); n = n + 4'd1;
            wlen_next = 3'd7;
          end
        end else begin
          if (wlen <= 3'(KW_BUF)) begin
            kw = kw_lookup(wbuf, wlen);
            if (kw[4]) begin
              recs[n[2:0]] = mkrec(1'b1, K_KW0 + {2'b00, kw[3:0]}, 8'd0, mk, 1'b0, 1'b0);
              n = n + 4'd1;
            end else begin
              for (int i = 0; i < KW_BUF; i++) begin
                if (i < int'(wlen)) begin
                  recs[n[2:0]] = mkrec(1'b0, K_IDENT, wbuf[i], mk, 1'b0, 1'b0);
                  n = n + 4'd1;
                end
              end
              recs[n[2:0]] = mkrec(1'b1, K_IDENT, 8'd0, mk, 1'b0, 1'b0); n = n + 4'd1;
            end
          end else begin
            recs[n[2:0]] = mkrec(1'b1, K_IDENT, 8'd0, mk, 1'b0, 1'b0); n = n + 4'd1;
          end
          do_idle = 1'b1;
        end
      end
      M_OPER: begin
        if (c == CH_EQ && pdl[2]) begin
          recs[n[2:0]] = mkrec(1'b1, K_OP2 + {4'd0, pdl[1:0]}, 8'd0, mk, 1'b0, 1'b0);
          n = n + 4'd1;
          mode_next = M_IDLE;
        end else begin
          pop = single_lookup(pend);
          if (pop[5]) begin
            recs[n[2:0]] = mkrec(1'b1, K_OP1 + {1'b0, pop[4:0]}, 8'd0, mk, 1'b0, 1'b0);
            n = n + 4'd1;
          end
          do_idle = 1'b1;
        end
      end
      default: do_idle = 1'b1;
    endcase

    if (do_idle) begin
      mode_next = M_IDLE;
      if (c == CH_SQ || c == CH_DQ) begin
        mk = 1'b1; sline_next = line; scol_next = col;
        oq_next   = c;
        mode_next = M_STRING;
      end else if (dl[2]) begin
        mk = 1'b1; sline_next = line; scol_next = col;
        pend_next = c;
        mode_next = M_OPER;
      end else if (op[5]) begin
        mk = 1'b1; sline_next = line; scol_next = col;
        recs[n[2:0]] = mkrec(1'b1, K_OP1 + {1'b0, op[4:0]}, 8'd0, mk, 1'b0, 1'b0);
        n = n + 4'd1;
      end else if (is_digit(c)) begin
        mk = 1'b1; sline_next = line; scol_next = col;
        dseen_next = 1'b0;
        recs[n[2:0]] = mkrec(1'b0, K_DEC, c, mk, 1'b0, 1'b0); n = n + 4'd1;
        mode_next = M_NUMBER;
      end else if (is_word_start(c)) begin
        mk = 1'b1; sline_next = line; scol_next = col;
        wbuf_next[0] = c;
        wlen_next    = 3'd1;
        mode_next    = M_WORD;
      end
    end

    if (end_of_text) begin
      case (mode_next)
        M_ESC: begin
          recs[n[2:0]] = mkrec(1'b0, K_STRING, CH_BSL, mk, 1'b0, 1'b0); n = n + 4'd1;
          recs[n[2:0]] = mkrec(1'b1, K_STRING, 8'd0, mk, 1'b1, 1'b1); n = n + 4'd1;
        end
        M_STRING: begin
          recs[n[2:0]] = mkrec(1'b1, K_STRING, 8'd0, mk, 1'b1, 1'b1); n = n + 4'd1;
        end
        M_NUMBER: begin
          recs[n[2:0]] = mkrec(1'b1, dseen_next ? K_FLOAT : K_DEC, 8'd0, mk, 1'b0, 1'b0);
          n = n + 4'd1;
        end
        M_WORD: begin
          if (wlen_next <= 3'(KW_BUF)) begin
            kw = kw_lookup(wbuf_next, wlen_next);
            if (kw[4]) begin
              recs[n[2:0]] = mkrec(1'b1, K_KW0 + {2'b00, kw[3:0]}, 8'd0, mk, 1'b0, 1'b0);
              n = n + 4'd1;
            end else begin
              for (int i = 0; i < KW_BUF; i++) begin
                if (i < int'(wlen_next)) begin
                  recs[n[2:0]] = mkrec(1'b0, K_IDENT, wbuf_next[i], mk, 1'b0, 1'b0);
                  n = n + 4'd1;
                end
              end
              recs[n[2:0]] = mkrec(1'b1, K_IDENT, 8'd0, mk, 1'b0, 1'b0); n = n + 4'd1;
            end
          end else begin
            recs[n[2:0]] = mkrec(1'b1, K_IDENT, 8'd0, mk, 1'b0, 1'b0); n = n + 4'd1;
          end
        end
        M_OPER: begin
          pop = single_lookup(pend_next);
          if (pop[5]) begin
            recs[n[2:0]] = mkrec(1'b1, K_OP1 + {1'b0, pop[4:0]}, 8'd0, mk, 1'b0, 1'b0);
            n = n + 4'd1;
          end
        end
        default: ;
      endcase
      mode_next = M_IDLE;
      line_next = '0;
      col_next  = '0;
    end else if (c == CH_LF) begin
      line_next = sat_inc(line);
      col_next  = '0;
    end else begin
      col_next = sat_inc(col);
    end

    burst.recs   = recs;
    burst.nrec   = n;
    burst.sline0 = sline;
    burst.scol0  = scol;
    burst.sline1 = sline_next;
    burst.scol1  = scol_next;
    burst.pline  = line;
    burst.pcol   = col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= M_IDLE;
      pend  <= '0;
      wlen  <= '0;
      dseen <= 1'b0;
      oq    <= '0;
      line  <= '0;
      col   <= '0;
      sline <= '0;
      scol  <= '0;
    end else if (take) begin
      mode  <= mode_next;
      pend  <= pend_next;
      wlen  <= wlen_next;
      dseen <= dseen_next;
      oq    <= oq_next;
      line  <= line_next;
      col   <= col_next;
      sline <= sline_next;
      scol  <= scol_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) wbuf <= wbuf_next;
  end

endmodule

/* rtl/source_text_tokenizer_core.sv */
// Top level of the source text tokenizer: scanner plus result burst register.
//
// Input channel: text_byte_in and end_of_text under in_valid / in_stall; one
// source byte per word, end_of_text set on the final byte of a text.
// Output channel: one record per word under out_valid / out_stall. Lexeme
// records (record_end 0) carry the text bytes of strings, numbers and
// identifiers ahead of the token's closing record (record_end 1).
// last_of_run marks the final record caused by one input byte.
// A byte is scanned in the cycle it is accepted; its records (0 to 8) sit in
// a burst register and leave one per cycle from the cycle after, while the
// receiver does not stall. The next byte is taken in the cycle the last
// record of the current burst leaves, so bytes with at most one record flow
// at one per cycle while the receiver does not stall. The drain of the burst
// register sets the byte rate.
// While the receiver stalls, the current record holds and in_stall rises
// once a burst is waiting. Reset empties the burst register and returns the
// scanner to idle with line and column at zero.
module source_text_tokenizer_core
  import sttok_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  text_byte_in,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        record_end,
  output logic [5:0]  token_kind,
  output logic [7:0]  lexeme_byte,
  output logic [15:0] start_line,
  output logic [15:0] start_column,
  output logic [15:0] end_line,
  output logic [15:0] end_column,
  output logic        unterminated,
  output logic        last_of_run
);

  burst_t     scan_burst, hold;
  logic [3:0] nrec;
  logic [2:0] idx;
  logic       take_in, take_out, last;
  rec_t       rec;

  sttok_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .take         (take_in),
    .text_byte_in (text_byte_in),
    .end_of_text  (end_of_text),
    .burst        (scan_burst)
  );

  assign out_valid = (nrec != 4'd0);
  assign last      = ({1'b0, idx} + 4'd1 == nrec);
  assign take_out  = out_valid && !out_stall;
  assign in_stall  = out_valid && !(take_out && last);
  assign take_in   = in_valid && !in_stall;
  assign rec       = hold.recs[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      nrec <= '0;
      idx  <= '0;
    end else if (take_in) begin
      nrec <= scan_burst.nrec;
      idx  <= '0;
    end else if (take_out) begin
      if (last) nrec <= '0;
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) hold <= scan_burst;
  end

  assign record_end   = rec.rend;
  assign token_kind   = rec.kind;
  assign lexeme_byte  = rec.lbyte;
  assign start_line   = rec.newst ? hold.sline1 : hold.sline0;
  assign start_column = rec.newst ? hold.scol1 : hold.scol0;
  assign end_line     = rec.endpos ? hold.pline : 16'd0;
  assign end_column   = rec.endpos ? hold.pcol : 16'd0;
  assign unterminated = rec.unterm;
  assign last_of_run  = last;

  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty burst register");

  a_end_pos_string: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind != K_STRING |-> end_line == 16'd0 && end_column == 16'd0)
    else $error("end position on a non-string record");

  a_unterm_close: assert property (@(posedge clk) disable iff (rst)
    out_valid && unterminated |-> record_end && token_kind == K_STRING)
    else $error("unterminated flag outside a string closing record");

endmodule
